FILE: rtl/nsf_pkg.sv
package nsf_pkg;

	// Default sentence buffer length in bytes.
	localparam int MAX_SENTENCE_LEN_DEF = 128;

	// Width of the reported buffer position.
	localparam int STORE_INDEX_W = 7;

	// Characters that matter to the framer.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Frame state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BODY = 3'd1;
	localparam logic [2:0] ST_HIGH = 3'd2;
	localparam logic [2:0] ST_LOW  = 3'd3;
	localparam logic [2:0] ST_CR   = 3'd4;
	localparam logic [2:0] ST_LF   = 3'd5;

	// Framing context carried from one byte to the next.
	typedef struct packed {
		logic [2:0] state;
		logic [7:0] run_xor;
		logic [7:0] high_char;
		logic [7:0] low_char;
	} frame_ctx_t;

	// Per-byte outcome of the framing step.
	typedef struct packed {
		logic store;
		logic start;
		logic ready;
		logic failed;
	} step_flags_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [3:0] nib;
		nib = 4'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			nib = ch[3:0];
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
			nib = ch[3:0] + 4'd9;
		end
		return nib;
	endfunction

	function automatic logic is_terminator(input logic [7:0] ch);
		return (ch == CH_CR) || (ch == CH_LF) || (ch == CH_DOLLAR) || (ch == CH_NUL);
	endfunction

endpackage

FILE: rtl/nsf_step.sv
module nsf_step
	import nsf_pkg::*;
#(
	parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF,
	localparam int PW = $clog2(MAX_SENTENCE_LEN)
) (
	input  logic [7:0]    ch,
	input  frame_ctx_t    ctx,
	input  logic [PW-1:0] pos,
	output frame_ctx_t    ctx_nxt,
	output logic [PW-1:0] pos_nxt,
	output logic [PW-1:0] index,
	output step_flags_t   flags
);

	logic [7:0] rx_sum;

	assign rx_sum = {hex_nibble(ctx.high_char), hex_nibble(ctx.low_char)};

	always_comb begin
		ctx_nxt = ctx;
		pos_nxt = pos;
		index   = pos;
		flags   = '0;
		flags.store = 1'b1;

		unique case (ctx.state)
			ST_IDLE: begin
				pos_nxt         = '0;
				ctx_nxt.run_xor = 8'd0;
				index           = '0;
				if (ch == CH_DOLLAR) begin
					flags.start   = 1'b1;
					ctx_nxt.state = ST_BODY;
				end else begin
					flags.store = 1'b0;
				end
			end
			ST_BODY: begin
				if (ch == CH_STAR) begin
					ctx_nxt.state = ST_HIGH;
				end else if (is_terminator(ch)) begin
					ctx_nxt.state = ST_IDLE;
				end else begin
					ctx_nxt.run_xor = ctx.run_xor ^ ch;
				end
			end
			ST_HIGH: begin
				// Repeated stars are stored and otherwise ignored.
				if (ch != CH_STAR) begin
					if (is_terminator(ch)) begin
						ctx_nxt.state = ST_IDLE;
					end else begin
						ctx_nxt.high_char = ch;
						ctx_nxt.state     = ST_LOW;
					end
				end
			end
			ST_LOW: begin
				if (is_terminator(ch)) begin
					ctx_nxt.state = ST_IDLE;
				end else begin
					ctx_nxt.low_char = ch;
					ctx_nxt.state    = ST_CR;
				end
			end
			ST_CR: begin
				ctx_nxt.state = (ch == CH_CR) ? ST_LF : ST_IDLE;
			end
			ST_LF: begin
				if (ch == CH_LF) begin
					if (rx_sum == ctx.run_xor) begin
						flags.ready = 1'b1;
					end else begin
						flags.failed = 1'b1;
					end
				end
				ctx_nxt.state = ST_IDLE;
			end
			default: begin
				flags.store = 1'b0;
			end
		endcase

		// A write into the last buffer slot ends the sentence.
		if (flags.store) begin
			pos_nxt = index + PW'(1);
			if (index == PW'(MAX_SENTENCE_LEN - 1)) begin
				ctx_nxt.state = ST_IDLE;
			end
		end
	end

endmodule

FILE: rtl/nmea_sentence_framer.sv
// Channel  | Handshake           | Words carried
// ---------+---------------------+---------------------------------------------
// rx       | rx_valid / rx_stall | rx_byte: one received character
// res      | res_valid/res_stall | store_*, sentence_ready, checksum_failed,
//          |                     | sentences_started, good_count, bad_count
//
// Every rx word yields exactly one res word, via the input register and then the
// result register; one word is accepted per cycle when nothing stalls, limited only by the
// single input register feeding the combinational framing step into the result register.
// arst_n clears the frame state, buffer position and all three counters.
// A stall on res holds the result register and, once the input register is
// also full, is passed back to rx as rx_stall.
module nmea_sentence_framer
	import nsf_pkg::*;
#(
	parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,

	output logic        res_valid,
	input  logic        res_stall,
	output logic        store_valid,
	output logic [STORE_INDEX_W-1:0] store_index,
	output logic [7:0]  store_byte,
	output logic        sentence_ready,
	output logic        checksum_failed,
	output logic [31:0] sentences_started,
	output logic [31:0] good_count,
	output logic [31:0] bad_count
);

	localparam int PW = $clog2(MAX_SENTENCE_LEN);
	// Wide enough both for the buffer position and for the reported index.
	localparam int IW = (PW > STORE_INDEX_W) ? PW : STORE_INDEX_W;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Frame context, buffer position and counters.
	frame_ctx_t    ctx_q;
	logic [PW-1:0] pos_q;
	logic [31:0]   started_q;
	logic [31:0]   good_q;
	logic [31:0]   bad_q;

	// Result register.
	logic        res_valid_q;
	logic        store_valid_q;
	logic [STORE_INDEX_W-1:0] store_index_q;
	logic [7:0]  store_byte_q;
	logic        ready_q;
	logic        failed_q;

	frame_ctx_t    ctx_nxt;
	logic [PW-1:0] pos_nxt;
	logic [PW-1:0] step_index;
	logic [IW-1:0] index_ext;
	step_flags_t   flags;

	logic rx_take;
	logic res_free;
	logic fire;

	// The result register can take a new word when it is empty or being drained.
	assign res_free = !res_valid_q || !res_stall;
	assign fire     = valid_s1 && res_free;
	assign rx_stall = valid_s1 && !res_free;
	assign rx_take  = rx_valid && !rx_stall;

	nsf_step #(
		.MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
	) u_step (
		.ch      (byte_s1),
		.ctx     (ctx_q),
		.pos     (pos_q),
		.ctx_nxt (ctx_nxt),
		.pos_nxt (pos_nxt),
		.index   (step_index),
		.flags   (flags)
	);

	assign index_ext = IW'(step_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	// Framing state advances only when the byte moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q     <= '{state: ST_IDLE, run_xor: 8'd0, high_char: 8'd0, low_char: 8'd0};
			pos_q     <= '0;
			started_q <= 32'd0;
			good_q    <= 32'd0;
			bad_q     <= 32'd0;
		end else if (fire) begin
			ctx_q <= ctx_nxt;
			pos_q <= pos_nxt;
			if (flags.start) begin
				started_q <= started_q + 32'd1;
			end
			if (flags.ready) begin
				good_q <= good_q + 32'd1;
			end
			if (flags.failed) begin
				bad_q <= bad_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Unstored bytes report zero index and byte.
	always_ff @(posedge clk) begin
		if (fire) begin
			store_valid_q <= flags.store;
			store_index_q <= flags.store ? index_ext[STORE_INDEX_W-1:0] : '0;
			store_byte_q  <= flags.store ? byte_s1 : 8'd0;
			ready_q       <= flags.ready;
			failed_q      <= flags.failed;
		end
	end

	assign res_valid         = res_valid_q;
	assign store_valid       = store_valid_q;
	assign store_index       = store_index_q;
	assign store_byte        = store_byte_q;
	assign sentence_ready    = ready_q;
	assign checksum_failed   = failed_q;
	// The counters only move when a result word is loaded, so they match it.
	assign sentences_started = started_q;
	assign good_count        = good_q;
	assign bad_count         = bad_q;

	// A byte can never be judged both good and bad.
	a_ready_xor_failed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(ready_q && failed_q))
		else $error("sentence reported both good and bad");

	// A good sentence bumps the good counter by exactly one.
	a_good_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && flags.ready) |=> (good_q == $past(good_q) + 32'd1))
		else $error("good counter did not follow a good sentence");

	// The input side is only held back while a byte waits in the input register.
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && res_valid_q))
		else $error("rx stalled with no word pending");

	// The buffer position stays inside the buffer.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(MAX_SENTENCE_LEN))
		else $error("buffer position out of range");

endmodule

FILE: test/nmea_sentence_framer_checker.sv
`timescale 1ns / 1ps

module nmea_sentence_framer_checker
	import nsf_pkg::*;
#(
	parameter int MAX_LEN = MAX_SENTENCE_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rx_valid,
	input  logic                     rx_stall,
	input  logic [7:0]               rx_byte,
	input  logic                     res_valid,
	input  logic                     res_stall,
	input  logic                     store_valid,
	input  logic [STORE_INDEX_W-1:0] store_index,
	input  logic [7:0]               store_byte,
	input  logic                     sentence_ready,
	input  logic                     checksum_failed,
	input  logic [31:0]              sentences_started,
	input  logic [31:0]              good_count,
	input  logic [31:0]              bad_count,
	output int                       mismatches,
	output int                       outstanding,
	output int                       words_checked,
	output int                       good_seen,
	output int                       bad_seen
);

	typedef struct packed {
		logic                     store;
		logic [STORE_INDEX_W-1:0] index;
		logic [7:0]               data;
		logic                     ready;
		logic                     failed;
		logic [31:0]              started;
		logic [31:0]              good;
		logic [31:0]              bad;
	} framer_word_t;

	// Our own copy of the framer state.
	logic [2:0]  frame;
	int unsigned fill;
	logic [7:0]  sum;
	logic [7:0]  high_char;
	logic [7:0]  low_char;
	logic [31:0] starts;
	logic [31:0] match_total;
	logic [31:0] misses;

	framer_word_t expected_words[$];

	function automatic logic [3:0] nibble(input logic [7:0] ch);
		if (ch >= CH_ZERO && ch <= CH_NINE) return 4'(ch - CH_ZERO);
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return 4'(ch - CH_UPPER_A + 8'd10);
		return 4'd0;
	endfunction

	function automatic logic breaks_frame(input logic [7:0] ch);
		return ch == CH_CR || ch == CH_LF || ch == CH_DOLLAR || ch == CH_NUL;
	endfunction

	// Advances the framer by one byte and returns the word it should report.
	task automatic frame_byte(input logic [7:0] ch, output framer_word_t w);
		logic        kept;
		int unsigned pos;
		kept = 1'b1;
		pos  = fill;
		w    = '0;
		case (frame)
		ST_IDLE: begin
			fill = 0;
			sum  = 8'h00;
			pos  = 0;
			if (ch == CH_DOLLAR) begin
				starts++;
				frame = ST_BODY;
			end else begin
				kept = 1'b0;
			end
		end
		ST_BODY: begin
			if (ch == CH_STAR) frame = ST_HIGH;
			else if (breaks_frame(ch)) frame = ST_IDLE;
			else sum = sum ^ ch;
		end
		ST_HIGH: begin
			if (ch != CH_STAR) begin
				if (breaks_frame(ch)) begin
					frame = ST_IDLE;
				end else begin
					high_char = ch;
					frame     = ST_LOW;
				end
			end
		end
		ST_LOW: begin
			if (breaks_frame(ch)) begin
				frame = ST_IDLE;
			end else begin
				low_char = ch;
				frame    = ST_CR;
			end
		end
		ST_CR: begin
			frame = (ch == CH_CR) ? ST_LF : ST_IDLE;
		end
		ST_LF: begin
			if (ch == CH_LF) begin
				if ({nibble(high_char), nibble(low_char)} == sum) begin
					match_total++;
					w.ready = 1'b1;
				end else begin
					misses++;
					w.failed = 1'b1;
				end
			end
			frame = ST_IDLE;
		end
		default: begin
			kept = 1'b0;
		end
		endcase
		if (kept) begin
			fill = pos + 1;
			if (fill >= MAX_LEN) frame = ST_IDLE;
			w.store = 1'b1;
			w.index = pos[STORE_INDEX_W-1:0];
			w.data  = ch;
		end
		w.started = starts;
		w.good    = match_total;
		w.bad     = misses;
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < 30) $display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	task automatic check_word(input framer_word_t got, input framer_word_t want);
		check_field("store_valid", got.store, want.store);
		check_field("store_index", got.index, want.index);
		check_field("store_byte", got.data, want.data);
		check_field("sentence_ready", got.ready, want.ready);
		check_field("checksum_failed", got.failed, want.failed);
		check_field("sentences_started", got.started, want.started);
		check_field("good_count", got.good, want.good);
		check_field("bad_count", got.bad, want.bad);
	endtask

	always @(posedge clk or negedge arst_n) begin
		framer_word_t got;
		framer_word_t want;
		if (!arst_n) begin
			frame       = ST_IDLE;
			fill        = 0;
			sum         = 8'h00;
			high_char   = 8'h00;
			low_char    = 8'h00;
			starts      = '0;
			match_total = '0;
			misses      = '0;
			expected_words.delete();
			mismatches    = 0;
			words_checked = 0;
			good_seen     = 0;
			bad_seen      = 0;
			outstanding  <= 0;
		end else begin
			// Results are retired before new words are predicted, so a stray
			// result can never be matched against a word accepted at the same edge.
			if (res_valid && !res_stall) begin
				got = '{store_valid, store_index, store_byte, sentence_ready,
					checksum_failed, sentences_started, good_count, bad_count};
				if (expected_words.size() == 0) begin
					report_mismatch("result word arrived with none outstanding");
				end else begin
					want = expected_words.pop_front();
					check_word(got, want);
					words_checked++;
					if (want.ready) good_seen++;
					if (want.failed) bad_seen++;
				end
			end
			if (rx_valid && !rx_stall) begin
				frame_byte(rx_byte, want);
				expected_words.push_back(want);
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

FILE: test/nmea_sentence_framer_test.sv
`timescale 1ns / 1ps

module nmea_sentence_framer_test
	import nsf_pkg::*;
();

	// Generous ceiling on the run; a correct run needs a small fraction of it.
	localparam int CYCLE_LIMIT   = 500000;
	// The random part is cut into chunks so that quiet and busy stretches
	// alternate and the sender can hold off between them.
	localparam int RANDOM_CHUNKS = 5;
	localparam int CHUNK_WORDS   = 140;
	// Clock cycles allowed after the last result for anything stray to show.
	localparam int TAIL_CYCLES   = 20;

	typedef enum int {
		SEQ_GOOD,
		SEQ_BAD_SUM,
		SEQ_ODD_DIGITS,
		SEQ_EARLY_END,
		SEQ_NO_CR,
		SEQ_NO_LF,
		SEQ_NOISE,
		SEQ_LONG
	} sentence_kind_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        rx_valid  = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte   = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        store_valid;
	logic [STORE_INDEX_W-1:0] store_index;
	logic [7:0]  store_byte;
	logic        sentence_ready;
	logic        checksum_failed;
	logic [31:0] sentences_started;
	logic [31:0] good_count;
	logic [31:0] bad_count;

	int mismatches;
	int outstanding;
	int words_checked;
	int good_seen;
	int bad_seen;

	// While calm is set neither side idles, giving back-to-back streaming.
	logic        calm        = 1'b0;
	int          stall_left  = 0;
	int unsigned cycle_count = 0;
	int          random_words = 0;

	// Bytes waiting to be offered on the rx channel.
	logic [7:0]  tx_bytes[$];

	nmea_sentence_framer i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_valid          (rx_valid),
		.rx_stall          (rx_stall),
		.rx_byte           (rx_byte),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.store_valid       (store_valid),
		.store_index       (store_index),
		.store_byte        (store_byte),
		.sentence_ready    (sentence_ready),
		.checksum_failed   (checksum_failed),
		.sentences_started (sentences_started),
		.good_count        (good_count),
		.bad_count         (bad_count)
	);

	nmea_sentence_framer_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_valid          (rx_valid),
		.rx_stall          (rx_stall),
		.rx_byte           (rx_byte),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.store_valid       (store_valid),
		.store_index       (store_index),
		.store_byte        (store_byte),
		.sentence_ready    (sentence_ready),
		.checksum_failed   (checksum_failed),
		.sentences_started (sentences_started),
		.good_count        (good_count),
		.bad_count         (bad_count),
		.mismatches        (mismatches),
		.outstanding       (outstanding),
		.words_checked     (words_checked),
		.good_seen         (good_seen),
		.bad_seen          (bad_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nmea_sentence_framer regression: fail");
			$finish;
		end
	end

	// Gap lengths come from the shortest range in three draws of four, from a middle
	// range in one of five, and rarely from a long pause that lets the pipeline fill or run dry.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// The result side stalls at random. Because a new decision is drawn whenever
	// no stall is running, the stalls land on every phase of the framer's work.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			res_stall <= 1'b0;
			if (!calm && $urandom_range(0, 4) == 0) stall_left <= gap_length();
		end
	end

	function automatic logic is_end_char(input logic [7:0] ch);
		return ch == CH_CR || ch == CH_LF || ch == CH_DOLLAR || ch == CH_NUL;
	endfunction

	// One of the four characters that cut a sentence short.
	function automatic logic [7:0] end_char();
		case ($urandom_range(0, 3))
		0: return CH_CR;
		1: return CH_LF;
		2: return CH_DOLLAR;
		default: return CH_NUL;
		endcase
	endfunction

	// A body character: mostly printable, sometimes any byte, but never one
	// that would end the body.
	function automatic logic [7:0] body_char();
		logic [7:0] ch;
		do begin
			if ($urandom_range(0, 3) != 0) ch = 8'($urandom_range(32, 126));
			else ch = 8'($urandom_range(0, 255));
		end while (ch == CH_STAR || is_end_char(ch));
		return ch;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_ZERO + {4'd0, n};
		return CH_UPPER_A + {4'd0, n - 4'd10};
	endfunction

	// A checksum character that may or may not be a proper digit: uppercase
	// hex, lowercase hex, other letters, or any byte that does not end the
	// sentence. A star is only offered for the low digit, where it is kept.
	function automatic logic [7:0] digit_char(input logic star_ok);
		logic [7:0] ch;
		do begin
			case ($urandom_range(0, 3))
			0: ch = hex_char(4'($urandom_range(0, 15)));
			1: ch = 8'($urandom_range(8'h61, 8'h66));
			2: ch = 8'($urandom_range(8'h47, 8'h5A));
			default: ch = 8'($urandom_range(0, 255));
			endcase
		end while (is_end_char(ch) || (!star_ok && ch == CH_STAR));
		return ch;
	endfunction

	function automatic sentence_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return SEQ_GOOD;
		if (r < 52) return SEQ_BAD_SUM;
		if (r < 62) return SEQ_ODD_DIGITS;
		if (r < 77) return SEQ_EARLY_END;
		if (r < 82) return SEQ_NO_CR;
		if (r < 87) return SEQ_NO_LF;
		if (r < 97) return SEQ_NOISE;
		return SEQ_LONG;
	endfunction

	// Appends one sentence of the given kind to the send queue. Counted is the
	// number of bytes queued for the sentence; idle noise is left out of it.
	task automatic append_sentence(input sentence_kind_t kind, output int counted);
		logic [7:0] text[$];
		logic [7:0] sum;
		logic [7:0] ch;
		int         len;
		int         cut;
		text    = {};
		sum     = 8'h00;
		counted = 0;
		if (kind == SEQ_NOISE) begin
			repeat ($urandom_range(1, 4)) begin
				do ch = 8'($urandom_range(0, 255)); while (ch == CH_DOLLAR);
				tx_bytes.push_back(ch);
			end
			return;
		end
		// Long bodies sit round the buffer limit: a sentence ending one byte short
		// of it, a final LF landing on the last position, the limit hit in the trailer,
		// on the star, on the last body byte, and well inside the body.
		if (kind == SEQ_LONG) begin
			case ($urandom_range(0, 5))
			0: len = 121;
			1: len = 122;
			2: len = 123;
			3: len = 126;
			4: len = 127;
			default: len = 140;
			endcase
		end else if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(13, 40);
		end else begin
			len = $urandom_range(0, 12);
		end
		text.push_back(CH_DOLLAR);
		repeat (len) begin
			ch  = body_char();
			sum = sum ^ ch;
			text.push_back(ch);
		end
		text.push_back(CH_STAR);
		// Extra stars before the high digit are stored but otherwise ignored.
		if (kind == SEQ_GOOD && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) text.push_back(CH_STAR);
		if (kind == SEQ_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
		if (kind == SEQ_ODD_DIGITS) begin
			text.push_back(digit_char(1'b0));
			text.push_back(digit_char(1'b1));
		end else begin
			text.push_back(hex_char(sum[7:4]));
			text.push_back(hex_char(sum[3:0]));
		end
		text.push_back(CH_CR);
		text.push_back(CH_LF);
		case (kind)
		SEQ_EARLY_END: begin
			// Cut in the body, on the star, or in either checksum digit.
			cut       = $urandom_range(1, len + 3);
			text[cut] = end_char();
			while (text.size() > cut + 1) text.delete(text.size() - 1);
		end
		SEQ_NO_CR: begin
			do ch = 8'($urandom_range(0, 255)); while (ch == CH_CR);
			text[text.size() - 2] = ch;
		end
		SEQ_NO_LF: begin
			do ch = 8'($urandom_range(0, 255)); while (ch == CH_LF);
			text[text.size() - 1] = ch;
		end
		default: begin
		end
		endcase
		foreach (text[i]) tx_bytes.push_back(text[i]);
		counted = text.size();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
	endtask

	// Offers one word and returns once it has been accepted. Valid is raised
	// only after any idle gap, so it never drops and rises in one time step.
	task automatic send_word(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0) gap = gap_length();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
	endtask

	task automatic send_all();
		while (tx_bytes.size() > 0) send_word(tx_bytes.pop_front());
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int chunk_words;
		int added;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Idle bytes at both ends of the byte range come first
		// and must be ignored without a store.
		tx_bytes.push_back(CH_NUL);
		tx_bytes.push_back(8'hFF);
		// A clean sentence whose checksum matches.
		push_text("$A*41");
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(CH_LF);
		// Lowercase and non-hex digits both read as zero, so this one fails.
		push_text("$B*gZ");
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(CH_LF);
		// A second dollar in the body aborts without starting a new sentence.
		push_text("$$");
		// A star before the high digit is ignored; a NUL in the low digit aborts.
		push_text("$**1");
		tx_bytes.push_back(CH_NUL);
		// An LF where the CR belongs aborts without counting.
		push_text("$*FF");
		tx_bytes.push_back(CH_LF);
		send_all();
		settle();

		// Random part: well-formed sentences with random content, mixed with
		// corrupted sentences and noise. Chunk two streams with no idling
		// on either side, and the sender waits for the pipeline to drain after
		// every odd chunk.
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			calm <= (chunk == 2);
			chunk_words = 0;
			if (chunk == 3) begin
				repeat (2) begin
					append_sentence(SEQ_LONG, added);
					chunk_words += added;
				end
			end
			while (chunk_words < CHUNK_WORDS) begin
				append_sentence(pick_kind(), added);
				chunk_words += added;
			end
			random_words += chunk_words;
			send_all();
			if (chunk % 2 == 1) settle();
		end
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("checked %0d result words: %0d sentences matched, %0d failed checksum",
			words_checked, good_seen, bad_seen);
		$display("random stimulus supplied %0d framed bytes beside the directed cases",
			random_words);
		if (mismatches == 0) begin
			$display("nmea_sentence_framer regression: pass");
		end else begin
			$display("nmea_sentence_framer regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/nsf_pkg.sv
rtl/nsf_step.sv
rtl/nmea_sentence_framer.sv
test/nmea_sentence_framer_checker.sv
test/nmea_sentence_framer_test.sv
